// ===== rtl/rqps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqps_pkg
// Shared types and codes for the ready queue priority select block.
// ----------------------------------------------------------------------------
package rqps_pkg;

	localparam int TAG_W  = 16;
	localparam int PRIO_W = 8;
	localparam int STAT_W = 2;
	localparam int STRAT_W = 2;

	localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_GRANTED  = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

	localparam logic [STRAT_W-1:0] STRAT_PRIO = 2'd1;

	localparam logic OP_ENQ  = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic enq;
		logic shift;
	} ctrl_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		entry_t            grant;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/ready_queue_priority_select.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ready_queue_priority_select
// Bounded ready queue of task tags in arrival order. Append, or take the
// oldest entry (fifo) or the highest-priority oldest entry (priority mode).
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  req      | req_valid / req_stall     | op, task_tag, task_priority
//  rsp      | rsp_valid / rsp_stall     | status, granted_tag, granted_priority
//  cfg      | cfg_write_en              | cfg_write_data (strategy)
//
//  Append, full, empty and fifo take: one item per cycle unless stalled.
//  Priority take: the search item is registered by each cell of the chain in
//  turn, then the selected slot and all later slots close up together.
//  Reset empties the queue and selects fifo; slot contents are not cleared.
//  One result may wait in the output register and one more in a skid slot;
//  req_stall rises only when both are full or a search is running.
// ----------------------------------------------------------------------------
module ready_queue_priority_select #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_write_en,
	input  wire [1:0]  cfg_write_data,
	input  wire        req_valid,
	output logic       req_stall,
	input  wire        op,
	input  wire [15:0] task_tag,
	input  wire [7:0]  task_priority,
	output logic       rsp_valid,
	input  wire        rsp_stall,
	output logic [1:0] status,
	output logic [15:0] granted_tag,
	output logic [7:0] granted_priority
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t                          state_q;
	logic [OCC_W-1:0]                occ_q;
	logic [rqps_pkg::STRAT_W-1:0]    strat_q;
	logic                            out_vld_q;
	rqps_pkg::result_t               out_q;
	logic                            pend_q;
	rqps_pkg::result_t               pend_data_q;

	rqps_pkg::ctrl_t                 ctrl;
	logic [IDX_W-1:0]                sel_idx;
	logic                            scan_start;
	rqps_pkg::entry_t                new_entry;
	rqps_pkg::entry_t                ent      [QUEUE_DEPTH];
	logic                            tok_vld  [QUEUE_DEPTH];
	rqps_pkg::entry_t                tok_best [QUEUE_DEPTH];
	logic [IDX_W-1:0]                tok_idx  [QUEUE_DEPTH];
	logic                            tok_done;
	logic                            req_acc;
	logic                            res_vld;
	rqps_pkg::result_t               res;
	logic                            slot_free;
	state_t                          state_d;
	logic [OCC_W-1:0]                occ_d;

	assign new_entry.tag  = task_tag;
	assign new_entry.prio = task_priority;

	assign req_stall = (state_q != S_IDLE) || pend_q;
	assign req_acc   = req_valid && !req_stall;
	assign tok_done  = tok_vld[QUEUE_DEPTH-1];

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			rqps_pkg::entry_t nxt;
			logic             tin_vld;
			rqps_pkg::entry_t tin_best;
			logic [IDX_W-1:0] tin_idx;

			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign nxt = ent[gi];
			end else begin : g_mid
				assign nxt = ent[gi+1];
			end

			if (gi == 0) begin : g_head
				assign tin_vld  = scan_start;
				assign tin_best = ent[0];
				assign tin_idx  = '0;
			end else begin : g_body
				assign tin_vld  = tok_vld[gi-1];
				assign tin_best = tok_best[gi-1];
				assign tin_idx  = tok_idx[gi-1];
			end

			rqps_cell #(
				.IDX_W    (IDX_W),
				.OCC_W    (OCC_W),
				.CELL_IDX (gi)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.occ          (occ_q),
				.sel_idx      (sel_idx),
				.new_entry    (new_entry),
				.next_entry   (nxt),
				.entry        (ent[gi]),
				.tok_in_vld   (tin_vld),
				.tok_in_best  (tin_best),
				.tok_in_idx   (tin_idx),
				.tok_out_vld  (tok_vld[gi]),
				.tok_out_best (tok_best[gi]),
				.tok_out_idx  (tok_idx[gi])
			);
		end
	endgenerate

	always_comb begin
		ctrl       = '0;
		sel_idx    = '0;
		scan_start = 1'b0;
		res_vld    = 1'b0;
		res        = '0;
		state_d    = state_q;
		occ_d      = occ_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					if (op == rqps_pkg::OP_ENQ) begin
						res_vld = 1'b1;
						if (occ_q == OCC_W'(QUEUE_DEPTH)) begin
							res.status = rqps_pkg::ST_FULL;
						end else begin
							res.status = rqps_pkg::ST_ACCEPTED;
							ctrl.enq   = 1'b1;
							occ_d      = occ_q + 1'b1;
						end
					end else if (occ_q == '0) begin
						res_vld    = 1'b1;
						res.status = rqps_pkg::ST_EMPTY;
					end else if (strat_q == rqps_pkg::STRAT_PRIO) begin
						scan_start = 1'b1;
						state_d    = S_SCAN;
					end else begin
						res_vld    = 1'b1;
						res.status = rqps_pkg::ST_GRANTED;
						res.grant  = ent[0];
						ctrl.shift = 1'b1;
						occ_d      = occ_q - 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (tok_done) begin
					res_vld    = 1'b1;
					res.status = rqps_pkg::ST_GRANTED;
					res.grant  = tok_best[QUEUE_DEPTH-1];
					ctrl.shift = 1'b1;
					sel_idx    = tok_idx[QUEUE_DEPTH-1];
					occ_d      = occ_q - 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign slot_free = !out_vld_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			strat_q   <= '0;
			out_vld_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			if (cfg_write_en) begin
				strat_q <= cfg_write_data;
			end
			if (res_vld) begin
				if (slot_free) begin
					out_vld_q <= 1'b1;
				end else begin
					pend_q <= 1'b1;
				end
			end else if (pend_q && slot_free) begin
				out_vld_q <= 1'b1;
				pend_q    <= 1'b0;
			end else if (slot_free) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			if (slot_free) begin
				out_q <= res;
			end else begin
				pend_data_q <= res;
			end
		end else if (pend_q && slot_free) begin
			out_q <= pend_data_q;
		end
	end

	assign rsp_valid        = out_vld_q;
	assign status           = out_q.status;
	assign granted_tag      = out_q.grant.tag;
	assign granted_priority = out_q.grant.prio;

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_vld_q)
		else $error("skid slot full while output register empty");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |->
			((occ_q == $past(occ_q) + 1'b1) || (occ_q + 1'b1 == $past(occ_q))))
		else $error("occupancy moved by more than one");

	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_done |-> (state_q == S_SCAN))
		else $error("search item left the chain outside a search");

	a_scan_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && !tok_done) |-> !res_vld)
		else $error("result produced mid search");

endmodule
`default_nettype wire

// ===== rtl/rqps_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqps_cell
// One queue slot: holds an entry, loads on append or close-up, and passes the
// running best-priority search item on to the next slot.
// ----------------------------------------------------------------------------
module rqps_cell #(
	parameter int IDX_W    = 4,
	parameter int OCC_W    = 5,
	parameter int CELL_IDX = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rqps_pkg::ctrl_t      ctrl,
	input  wire [OCC_W-1:0]      occ,
	input  wire [IDX_W-1:0]      sel_idx,
	input  rqps_pkg::entry_t     new_entry,
	input  rqps_pkg::entry_t     next_entry,
	output rqps_pkg::entry_t     entry,
	input  wire                  tok_in_vld,
	input  rqps_pkg::entry_t     tok_in_best,
	input  wire [IDX_W-1:0]      tok_in_idx,
	output logic                 tok_out_vld,
	output rqps_pkg::entry_t     tok_out_best,
	output logic [IDX_W-1:0]     tok_out_idx
);

	rqps_pkg::entry_t ent_q;
	rqps_pkg::entry_t tok_best_q;
	logic [IDX_W-1:0] tok_idx_q;
	logic             tok_vld_q;
	logic             live;
	logic             wins;

	assign live = OCC_W'(CELL_IDX) < occ;
	assign wins = live && (ent_q.prio > tok_in_best.prio);

	always_ff @(posedge clk) begin
		if (ctrl.enq && (OCC_W'(CELL_IDX) == occ)) begin
			ent_q <= new_entry;
		end else if (ctrl.shift && (IDX_W'(CELL_IDX) >= sel_idx)) begin
			ent_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in_vld) begin
			if (wins) begin
				tok_best_q <= ent_q;
				tok_idx_q  <= IDX_W'(CELL_IDX);
			end else begin
				tok_best_q <= tok_in_best;
				tok_idx_q  <= tok_in_idx;
			end
		end
	end

	assign entry        = ent_q;
	assign tok_out_vld  = tok_vld_q;
	assign tok_out_best = tok_best_q;
	assign tok_out_idx  = tok_idx_q;

endmodule
`default_nettype wire
